### sv/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 4;
    localparam int ID_BITS       = 16;
    localparam int IDX_BITS      = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                     func;
        logic [ID_BITS-1:0]       proc_id;
        logic [PRIORITY_BITS-1:0] priority_req;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [ID_BITS-1:0]       out_id;
        logic [PRIORITY_BITS-1:0] out_priority;
        logic [CNT_BITS-1:0]      occupancy;
    } out_item_t;

    typedef struct packed {
        logic [ID_BITS-1:0]       id;
        logic [PRIORITY_BITS-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] addr;
        entry_t              data;
    } store_wr_t;

endpackage
`default_nettype wire

### sv/spq_store.sv
`timescale 1ns / 1ps
`default_nettype none
module spq_store
    import spq_pkg::*;
(
    input  wire logic                clk,
    input  wire store_wr_t           wr,
    input  wire logic [IDX_BITS-1:0] rd_addr,
    output entry_t                   rd_data
);

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### sv/stable_priority_ready_queue_top.sv
// Insert answers from S_IDLE when full or empty; else S_INS_RD/S_INS_WR move each
// higher-priority entry back a slot. Extract answers from S_IDLE when empty; else it reads
// the head and shifts the rest down. One item at a time, paced by the registered-read store.
// The result strobe rises for one cycle at the end of the item; the receiver cannot stall.
// Reset empties the queue; slot contents are not cleared and never read before written.
`timescale 1ns / 1ps
`default_nettype none
module stable_priority_ready_queue_top
    import spq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire in_item_t in_item,
    output logic          done,
    output out_item_t     result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_EXT_HEAD,
        S_EXT_RD,
        S_EXT_WR
    } state_t;

    state_t              state_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [IDX_BITS-1:0] hole_reg;
    entry_t              new_reg;
    entry_t              head_reg;
    logic                done_reg;
    out_item_t           result_reg;

    store_wr_t           wr;
    logic [IDX_BITS-1:0] rd_addr;
    entry_t              rd_data;
    logic                accept;

    assign accept = start && (state_reg == S_IDLE);

    spq_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        wr      = '0;
        rd_addr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_item.func == FUNC_INSERT && count_reg == '0)
                begin
                    wr.en   = 1'b1;
                    wr.addr = '0;
                    wr.data = '{id: in_item.proc_id, prio: in_item.priority_req};
                end
            end
            S_INS_RD:
            begin
                if (hole_reg == '0)
                begin
                    wr.en   = 1'b1;
                    wr.addr = '0;
                    wr.data = new_reg;
                end
                else
                begin
                    rd_addr = hole_reg - 1'b1;
                end
            end
            S_INS_WR:
            begin
                wr.en   = 1'b1;
                wr.addr = hole_reg;
                wr.data = (rd_data.prio > new_reg.prio) ? rd_data : new_reg;
            end
            S_EXT_HEAD:
            begin
                rd_addr = '0;
            end
            S_EXT_RD:
            begin
                rd_addr = hole_reg + 1'b1;
            end
            S_EXT_WR:
            begin
                wr.en   = 1'b1;
                wr.addr = hole_reg;
                wr.data = rd_data;
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        new_reg <= '{id: in_item.proc_id, prio: in_item.priority_req};
                        if (in_item.func == FUNC_INSERT)
                        begin
                            if (count_reg == CNT_BITS'(QUEUE_DEPTH))
                            begin
                                done_reg   <= 1'b1;
                                result_reg <= '{status: ST_FULL, out_id: '0,
                                               out_priority: '0, occupancy: count_reg};
                            end
                            else if (count_reg == '0)
                            begin
                                count_reg  <= CNT_BITS'(1);
                                done_reg   <= 1'b1;
                                result_reg <= '{status: ST_DONE, out_id: '0,
                                               out_priority: '0, occupancy: CNT_BITS'(1)};
                            end
                            else
                            begin
                                hole_reg  <= count_reg[IDX_BITS-1:0];
                                state_reg <= S_INS_RD;
                            end
                        end
                        else
                        begin
                            if (count_reg == '0)
                            begin
                                done_reg   <= 1'b1;
                                result_reg <= '{status: ST_EMPTY, out_id: '0,
                                               out_priority: '0, occupancy: '0};
                            end
                            else
                            begin
                                state_reg <= S_EXT_HEAD;
                            end
                        end
                    end
                end
                S_INS_RD:
                begin
                    if (hole_reg == '0)
                    begin
                        count_reg  <= count_reg + 1'b1;
                        done_reg   <= 1'b1;
                        result_reg <= '{status: ST_DONE, out_id: '0,
                                       out_priority: '0, occupancy: count_reg + 1'b1};
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_INS_WR;
                    end
                end
                S_INS_WR:
                begin
                    // move the larger entry up and keep scanning, else drop the new one in
                    if (rd_data.prio > new_reg.prio)
                    begin
                        hole_reg  <= hole_reg - 1'b1;
                        state_reg <= S_INS_RD;
                    end
                    else
                    begin
                        count_reg  <= count_reg + 1'b1;
                        done_reg   <= 1'b1;
                        result_reg <= '{status: ST_DONE, out_id: '0,
                                       out_priority: '0, occupancy: count_reg + 1'b1};
                        state_reg  <= S_IDLE;
                    end
                end
                S_EXT_HEAD:
                begin
                    head_reg <= rd_data;
                    hole_reg <= '0;
                    if (count_reg == CNT_BITS'(1))
                    begin
                        count_reg  <= '0;
                        done_reg   <= 1'b1;
                        result_reg <= '{status: ST_DONE, out_id: rd_data.id,
                                       out_priority: rd_data.prio, occupancy: '0};
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_EXT_RD;
                    end
                end
                S_EXT_RD:
                begin
                    state_reg <= S_EXT_WR;
                end
                S_EXT_WR:
                begin
                    hole_reg <= hole_reg + 1'b1;
                    // last entry moved down once the next hole is the old tail
                    if ({1'b0, hole_reg} + CNT_BITS'(2) == count_reg)
                    begin
                        count_reg  <= count_reg - 1'b1;
                        done_reg   <= 1'b1;
                        result_reg <= '{status: ST_DONE, out_id: head_reg.id,
                                       out_priority: head_reg.prio,
                                       occupancy: count_reg - 1'b1};
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_EXT_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire
